// File: rtl/core/btff_pkg.sv
// Package for the boundary-tag first-fit allocator.
// Beat types, status codes, tag layout and saturating counter helpers.
// No dependencies.
package btff_pkg;

    localparam int SIZE_W   = 13;
    localparam int TAG_W    = 14;
    localparam int OFF_W    = 12;
    localparam int POS_W    = 15;
    localparam int OVERHEAD = 2;
    localparam int ARENA_MIN = 4;
    localparam int ARENA_RST = 4096;
    localparam logic [SIZE_W-1:0] CNT_MAX = '1;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_BADOFF = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [OFF_W-1:0] request_words;
        logic [OFF_W-1:0] block_offset;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]        status;
        logic [OFF_W-1:0]  granted_offset;
        logic [SIZE_W-1:0] free_word_total;
        logic [SIZE_W-1:0] free_block_total;
    } t_out_beat;

    function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b);
        logic [SIZE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SIZE_W] ? CNT_MAX : s[SIZE_W-1:0];
    endfunction

    function automatic logic [SIZE_W-1:0] sat_sub(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

endpackage

// File: rtl/core/btff_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module btff_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/boundary_tag_first_fit_allocator_top.sv
// Boundary-tag first-fit allocator: top level with the control sequencer.
// Uses btff_pkg and btff_ram (tag store).
//
// One item is in flight at a time; a new beat is taken once the previous
// one has been handed to the output register. Every item is accepted in
// idle and has its result posted from the done state, which waits while
// the output is stalled. An allocate does a tag store read, then a check,
// for each block visited on the first-fit walk, a final read when the walk
// runs off the arena end, and 2 or 4 tag writes on a hit. A free does the
// header read and check, stopping there on a bad offset, then two tag
// writes, then a read and up to two writes each for merging with the next
// and the previous block. Each state makes at most one tag-store access.
// After reset and after every arena_words write, the block clears
// arena_words entries and writes the two initial tags before taking beats.
module boundary_tag_first_fit_allocator_top #(
    parameter int MEM_WORDS = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [12:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  btff_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output btff_pkg::t_out_beat o_out_beat
);
    localparam int AW = $clog2(MEM_WORDS);
    localparam int SW = btff_pkg::SIZE_W;
    localparam int PW = btff_pkg::POS_W;
    localparam logic [SW-1:0] ARENA_RST_V =
        SW'((btff_pkg::ARENA_RST > MEM_WORDS) ? MEM_WORDS : btff_pkg::ARENA_RST);

    typedef enum logic [22:0] {
        S_IDLE   = 23'h000001, S_CLR    = 23'h000002, S_INIT_H = 23'h000004,
        S_INIT_F = 23'h000008, S_A_RD   = 23'h000010, S_A_CHK  = 23'h000020,
        S_A_W1   = 23'h000040, S_A_W2   = 23'h000080, S_A_W3   = 23'h000100,
        S_A_W4   = 23'h000200, S_F_RD   = 23'h000400, S_F_CHK  = 23'h000800,
        S_F_W1   = 23'h001000, S_F_W2   = 23'h002000, S_F_NRD  = 23'h004000,
        S_F_NCHK = 23'h008000, S_F_NW1  = 23'h010000, S_F_NW2  = 23'h020000,
        S_F_PRD  = 23'h040000, S_F_PCHK = 23'h080000, S_F_PW1  = 23'h100000,
        S_F_PW2  = 23'h200000, S_DONE   = 23'h400000
    } t_state;

    function automatic logic [SW-1:0] clamp_arena(input logic [SW-1:0] v);
        logic [SW-1:0] r;
        r = v;
        if (r < SW'(btff_pkg::ARENA_MIN)) r = SW'(btff_pkg::ARENA_MIN);
        else if (32'(r) > MEM_WORDS) r = SW'(MEM_WORDS);
        return r;
    endfunction

    t_state r_state, n_state;
    logic [SW-1:0] r_arena, n_arena;
    logic [SW-1:0] r_fwc, n_fwc;
    logic [SW-1:0] r_fbc, n_fbc;
    logic [SW-1:0] r_clr, n_clr;
    logic [PW-1:0] r_cur, n_cur;
    logic [SW-1:0] r_need, n_need;
    logic [SW-1:0] r_sz, n_sz;
    logic [SW-1:0] r_tot, n_tot;
    logic [SW-1:0] r_ps, n_ps;
    logic [btff_pkg::OFF_W-1:0] r_blk, n_blk;
    logic [1:0] r_status, n_status;
    logic [btff_pkg::OFF_W-1:0] r_granted, n_granted;
    logic r_out_valid, n_out_valid;
    btff_pkg::t_out_beat r_out, n_out;

    logic wr_want;
    logic [PW-1:0] wr_pos, rd_pos, blk_pos;
    logic [btff_pkg::TAG_W-1:0] wr_tag, rd_tag;
    logic mem_we;
    logic [SW-1:0] t_sz, rem;
    logic t_alloc;

    btff_ram #(.WIDTH(btff_pkg::TAG_W), .DEPTH(MEM_WORDS)) u_tags (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(AW'(wr_pos)),
        .i_wdata(wr_tag),
        .i_raddr(AW'(rd_pos)),
        .o_rdata(rd_tag)
    );

    assign blk_pos = PW'(r_blk);
    assign t_sz    = rd_tag[btff_pkg::TAG_W-1:1];
    assign t_alloc = rd_tag[0];
    assign rem     = r_sz - r_need;
    // tags beyond the arena are never written
    assign mem_we  = wr_want && (wr_pos < PW'(r_arena));

    always_comb begin
        n_state = r_state; n_arena = r_arena; n_fwc = r_fwc; n_fbc = r_fbc;
        n_clr = r_clr; n_cur = r_cur; n_need = r_need; n_sz = r_sz;
        n_tot = r_tot; n_ps = r_ps; n_blk = r_blk; n_status = r_status;
        n_granted = r_granted; n_out_valid = r_out_valid; n_out = r_out;
        wr_want = 1'b0; wr_pos = '0; wr_tag = '0; rd_pos = '0;

        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_need    = SW'(i_in_beat.request_words) + SW'(btff_pkg::OVERHEAD);
                    n_blk     = i_in_beat.block_offset;
                    n_cur     = '0;
                    n_granted = '0;
                    n_status  = btff_pkg::ST_DONE;
                    n_state   = (i_in_beat.operation == btff_pkg::OP_FREE) ? S_F_RD : S_A_RD;
                end
            end
            S_CLR: begin
                wr_want = 1'b1; wr_pos = PW'(r_clr); wr_tag = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == r_arena - 1'b1) n_state = S_INIT_H;
            end
            S_INIT_H: begin
                wr_want = 1'b1; wr_pos = '0; wr_tag = {r_arena, 1'b0};
                n_state = S_INIT_F;
            end
            S_INIT_F: begin
                wr_want = 1'b1; wr_pos = PW'(r_arena - 1'b1); wr_tag = {r_arena, 1'b0};
                n_state = S_IDLE;
            end
            // first-fit walk
            S_A_RD: begin
                rd_pos = r_cur;
                if (r_cur >= PW'(r_arena)) begin
                    n_status = btff_pkg::ST_NOFIT;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (t_sz == '0) begin
                    n_status = btff_pkg::ST_NOFIT;
                    n_state  = S_DONE;
                end else if (!t_alloc && t_sz >= r_need) begin
                    n_sz      = t_sz;
                    n_granted = r_cur[btff_pkg::OFF_W-1:0];
                    n_state   = S_A_W1;
                end else begin
                    n_cur   = r_cur + PW'(t_sz);
                    n_state = S_A_RD;
                end
            end
            S_A_W1: begin
                wr_want = 1'b1; wr_pos = r_cur; wr_tag = {r_need, 1'b1};
                n_fwc = btff_pkg::sat_sub(r_fwc, r_need);
                if (r_sz == r_need) n_fbc = btff_pkg::sat_sub(r_fbc, SW'(1));
                n_state = S_A_W2;
            end
            S_A_W2: begin
                wr_want = 1'b1; wr_pos = r_cur + PW'(r_need) - 1'b1;
                wr_tag  = {r_need, 1'b1};
                n_state = (r_sz > r_need) ? S_A_W3 : S_DONE;
            end
            S_A_W3: begin
                wr_want = 1'b1; wr_pos = r_cur + PW'(r_need); wr_tag = {rem, 1'b0};
                n_state = S_A_W4;
            end
            S_A_W4: begin
                wr_want = 1'b1; wr_pos = r_cur + PW'(r_sz) - 1'b1; wr_tag = {rem, 1'b0};
                n_state = S_DONE;
            end
            // free and coalesce
            S_F_RD: begin
                rd_pos  = blk_pos;
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                if (blk_pos >= PW'(r_arena) || !t_alloc || t_sz == '0) begin
                    n_status = btff_pkg::ST_BADOFF;
                    n_state  = S_DONE;
                end else begin
                    n_sz    = t_sz;
                    n_state = S_F_W1;
                end
            end
            S_F_W1: begin
                wr_want = 1'b1; wr_pos = blk_pos; wr_tag = {r_sz, 1'b0};
                n_fwc = btff_pkg::sat_add(r_fwc, r_sz);
                n_fbc = btff_pkg::sat_add(r_fbc, SW'(1));
                n_state = S_F_W2;
            end
            S_F_W2: begin
                wr_want = 1'b1; wr_pos = blk_pos + PW'(r_sz) - 1'b1; wr_tag = {r_sz, 1'b0};
                n_state = (blk_pos + PW'(r_sz) < PW'(r_arena)) ? S_F_NRD : S_F_PRD;
            end
            S_F_NRD: begin
                rd_pos  = blk_pos + PW'(r_sz);
                n_state = S_F_NCHK;
            end
            S_F_NCHK: begin
                if (!t_alloc) begin
                    n_sz    = r_sz + t_sz;
                    n_fbc   = btff_pkg::sat_sub(r_fbc, SW'(1));
                    n_state = S_F_NW1;
                end else begin
                    n_state = S_F_PRD;
                end
            end
            S_F_NW1: begin
                wr_want = 1'b1; wr_pos = blk_pos; wr_tag = {r_sz, 1'b0};
                n_state = S_F_NW2;
            end
            S_F_NW2: begin
                wr_want = (r_sz != '0);
                wr_pos  = blk_pos + PW'(r_sz) - 1'b1; wr_tag = {r_sz, 1'b0};
                n_state = S_F_PRD;
            end
            S_F_PRD: begin
                rd_pos  = blk_pos - 1'b1;
                n_state = (r_blk != '0) ? S_F_PCHK : S_DONE;
            end
            S_F_PCHK: begin
                if (!t_alloc) begin
                    n_ps    = t_sz;
                    n_tot   = t_sz + r_sz;
                    n_fbc   = btff_pkg::sat_sub(r_fbc, SW'(1));
                    n_state = S_F_PW1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_F_PW1: begin
                // skipped when the previous size reaches below offset zero
                wr_want = (PW'(r_ps) <= blk_pos);
                wr_pos  = blk_pos - PW'(r_ps); wr_tag = {r_tot, 1'b0};
                n_state = S_F_PW2;
            end
            S_F_PW2: begin
                wr_want = (r_sz != '0);
                wr_pos  = blk_pos + PW'(r_sz) - 1'b1; wr_tag = {r_tot, 1'b0};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out.status           = r_status;
                    n_out.granted_offset   = r_granted;
                    n_out.free_word_total  = r_fwc;
                    n_out.free_block_total = r_fbc;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // arena re-form restarts the clear sweep
        if (i_cfg_we) begin
            n_arena = clamp_arena(i_cfg_wdata);
            n_fwc   = clamp_arena(i_cfg_wdata);
            n_fbc   = SW'(1);
            n_clr   = '0;
            n_state = S_CLR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_arena     <= ARENA_RST_V;
            r_fwc       <= ARENA_RST_V;
            r_fbc       <= SW'(1);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_arena     <= n_arena;
            r_fwc       <= n_fwc;
            r_fbc       <= n_fbc;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_cur     <= n_cur;
        r_need    <= n_need;
        r_sz      <= n_sz;
        r_tot     <= n_tot;
        r_ps      <= n_ps;
        r_blk     <= n_blk;
        r_status  <= n_status;
        r_granted <= n_granted;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;
endmodule

// File: rtl/core/btff_chk.sv
// Port-level checker for the allocator, bound to the top level.
// Uses btff_pkg.
module btff_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_cfg_we,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input btff_pkg::t_out_beat o_out_beat
);
    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("beat accepted back to back");

    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_in_stall)
        else $error("input open during arena re-form");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.status != btff_pkg::ST_DONE
        |-> o_out_beat.granted_offset == '0)
        else $error("nonzero offset on failed result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_beat.status == btff_pkg::ST_DONE ||
                        o_out_beat.status == btff_pkg::ST_NOFIT ||
                        o_out_beat.status == btff_pkg::ST_BADOFF)
        else $error("bad status code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("stalled result beat changed");
endmodule

bind boundary_tag_first_fit_allocator_top btff_chk u_btff_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_cfg_we   (i_cfg_we),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_beat (o_out_beat)
);
